FILE: hw/rtl/wsa_pkg.sv
// Shared types and constants of the worker slot allocator.
// Depends on nothing; the top level, the checker and the testbench import it.
package wsa_pkg;

   // Table sizes and key width
   localparam int SlotCount   = 64;
   localparam int CoolEntries = 64;
   localparam int KeyBits     = 32;
   localparam int ClockBits   = 32;

   localparam int SlotIdxBits = (SlotCount > 1) ? $clog2(SlotCount) : 1;
   localparam int CoolIdxBits = (CoolEntries > 1) ? $clog2(CoolEntries) : 1;
   localparam int ScanDepth   = (SlotCount > CoolEntries) ? SlotCount : CoolEntries;
   localparam int ScanIdxBits = (ScanDepth > 1) ? $clog2(ScanDepth) : 1;
   localparam int ScanCntBits = $clog2(ScanDepth + 1);
   localparam int CountBits   = $clog2(SlotCount + 1);

   // Port field widths
   localparam int ActionBits    = 2;
   localparam int ItemKeyBits   = 32;
   localparam int SlotPortBits  = 6;
   localparam int StatusBits    = 3;
   localparam int CountPortBits = 7;
   localparam int LimitBits     = 7;
   localparam int TicksBits     = 16;
   localparam int CsrIndexBits  = 2;
   localparam int CsrDataBits   = 16;

   localparam logic [LimitBits-1:0] LimitReset = LimitBits'(8);
   localparam logic [TicksBits-1:0] TicksReset = TicksBits'(30);

   typedef enum logic [ActionBits-1:0] {
      ACT_CLAIM   = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_CLEAR   = 2'd2,
      ACT_TICK    = 2'd3
   } action_type;

   typedef enum logic [StatusBits-1:0] {
      ST_GRANTED  = 3'd0,
      ST_CAPACITY = 3'd1,
      ST_INFLIGHT = 3'd2,
      ST_COOLING  = 3'd3,
      ST_DONE     = 3'd4
   } status_type;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_LIMIT  = 2'd0,
      CSR_TICKS  = 2'd1,
      CSR_ENABLE = 2'd2
   } csr_index_type;

endpackage

FILE: hw/rtl/wsa_ram.sv
// Generic single-write, single-read memory with registered read data.
// Depends on nothing; used for the slot key and cooldown tables.
module wsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/worker_slot_allocator_with_cooldown_top.sv
// Worker slot allocator with cooldown: top level, sequencer and state.
// Depends on wsa_pkg and wsa_ram.
//
//  channel  ports                                         transfers on
//  -------  --------------------------------------------  ---------------------
//  request  req_action/item_key/slot_index/backoff        req_valid & req_ready
//  response rsp_status/granted_slot/active_count          rsp_valid & rsp_ready
//  csr      csr_index, csr_wr_data                        csr_wr_en
//
// A claim walks both tables once through the shared compare stage: one read
// per entry, each compared after the registered read, then the result goes
// through S_RESP into the response register. A release reads its slot and
// checks it; with backoff it also walks the cooldown table once, cut short at
// an entry already holding the key. Clear and tick go straight to S_RESP. The
// request side reopens at the clock edge that loads the response register.
// Reset is synchronous and clears valid bits, counters, state and
// configuration registers at once; no clearing pass. A stalled response
// holds in its register while the next request transaction is accepted; a
// finished item waits until the response register is free.
module worker_slot_allocator_with_cooldown_top (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [wsa_pkg::ActionBits-1:0]    req_action,
   input  logic [wsa_pkg::ItemKeyBits-1:0]   req_item_key,
   input  logic [wsa_pkg::SlotPortBits-1:0]  req_slot_index,
   input  logic                              req_backoff,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [wsa_pkg::StatusBits-1:0]    rsp_status,
   output logic [wsa_pkg::SlotPortBits-1:0]  rsp_granted_slot,
   output logic [wsa_pkg::CountPortBits-1:0] rsp_active_count,
   // configuration writes
   input  logic                              csr_wr_en,
   input  logic [wsa_pkg::CsrIndexBits-1:0]  csr_index,
   input  logic [wsa_pkg::CsrDataBits-1:0]   csr_wr_data
);
   import wsa_pkg::*;

   localparam logic [ScanCntBits-1:0] ScanEnd  = ScanCntBits'(ScanDepth);
   localparam logic [ScanIdxBits-1:0] ScanLast = ScanIdxBits'(ScanDepth - 1);
   localparam logic [ScanCntBits-1:0] CoolEnd  = ScanCntBits'(CoolEntries);
   localparam logic [ScanCntBits-1:0] SlotEnd  = ScanCntBits'(SlotCount);
   localparam int CoolWidth = KeyBits + ClockBits;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_REL_READ,
      S_REL_CHECK,
      S_ARM,
      S_RESP
   } state_type;

   // Sequencer and latched request
   state_type                  state_ff,       state_in;
   action_type                 action_ff,      action_in;
   logic [KeyBits-1:0]         key_ff,         key_in;
   logic [SlotPortBits-1:0]    slot_ff,        slot_in;
   logic                       backoff_ff,     backoff_in;

   // Walk counter and the compare stage behind the memory read
   logic [ScanCntBits-1:0]     scan_cnt_ff,    scan_cnt_in;
   logic                       cmp_vld_ff,     cmp_vld_in;
   logic [ScanIdxBits-1:0]     cmp_idx_ff,     cmp_idx_in;

   // Claim findings
   logic                       cool_seen_ff,   cool_seen_in;
   logic                       cooling_ff,     cooling_in;
   logic                       inflight_ff,    inflight_in;
   logic                       free_found_ff,  free_found_in;
   logic [SlotIdxBits-1:0]     free_idx_ff,    free_idx_in;

   // Cooldown victim choice
   logic                       pick_vld_ff,    pick_vld_in;
   logic [CoolIdxBits-1:0]     pick_idx_ff,    pick_idx_in;
   logic [ClockBits-1:0]       earliest_ff,    earliest_in;

   // Result waiting for the response register
   status_type                 res_status_ff,  res_status_in;
   logic [SlotIdxBits-1:0]     res_slot_ff,    res_slot_in;

   // Architectural state
   logic [SlotCount-1:0]       slot_active_ff, slot_active_in;
   logic [CoolEntries-1:0]     cool_vld_ff,    cool_vld_in;
   logic [CountBits-1:0]       total_ff,       total_in;
   logic [ClockBits-1:0]       now_ff,         now_in;

   // Configuration
   logic [LimitBits-1:0]       limit_ff,       limit_in;
   logic [TicksBits-1:0]       ticks_ff,       ticks_in;
   logic                       enabled_ff,     enabled_in;

   // Response register
   logic                       rsp_valid_ff,   rsp_valid_in;
   status_type                 rsp_status_ff,  rsp_status_in;
   logic [SlotPortBits-1:0]    rsp_slot_ff,    rsp_slot_in;
   logic [CountPortBits-1:0]   rsp_count_ff,   rsp_count_in;

   // Memory ports
   logic                       slot_we;
   logic [SlotIdxBits-1:0]     slot_waddr;
   logic [SlotIdxBits-1:0]     slot_raddr;
   logic [KeyBits-1:0]         slot_rkey;
   logic                       cool_we;
   logic [CoolIdxBits-1:0]     cool_waddr;
   logic [CoolWidth-1:0]       cool_rdata;

   // Compare stage
   logic [CoolIdxBits-1:0]     cidx;
   logic [SlotIdxBits-1:0]     sidx;
   logic [SlotIdxBits-1:0]     rel_idx;
   logic                       in_cool;
   logic                       in_slot;
   logic                       cmp_last;
   logic [KeyBits-1:0]         eff_key;
   logic [ClockBits-1:0]       eff_exp;
   logic                       cool_key_hit;
   logic                       slot_key_hit;
   logic [ClockBits-1:0]       lt_a;
   logic [ClockBits-1:0]       lt_b;
   logic                       lt;
   logic [ClockBits:0]         expiry_sum;
   logic [ClockBits-1:0]       expiry;
   logic                       req_fire;

   wsa_ram #(
      .WIDTH (KeyBits),
      .DEPTH (SlotCount)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (key_ff),
      .rd_addr (slot_raddr),
      .rd_data (slot_rkey)
   );

   wsa_ram #(
      .WIDTH (CoolWidth),
      .DEPTH (CoolEntries)
   ) u_cool_ram (
      .clock   (clock),
      .wr_en   (cool_we),
      .wr_addr (cool_waddr),
      .wr_data ({key_ff, expiry}),
      .rd_addr (scan_cnt_ff[CoolIdxBits-1:0]),
      .rd_data (cool_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Walk the slot table during a claim, else read the slot being released
   assign slot_raddr = (state_ff == S_SCAN) ? scan_cnt_ff[SlotIdxBits-1:0] :
                                              SlotIdxBits'(slot_ff);
   assign rel_idx    = SlotIdxBits'(slot_ff);

   assign cidx     = cmp_idx_ff[CoolIdxBits-1:0];
   assign sidx     = cmp_idx_ff[SlotIdxBits-1:0];
   assign in_cool  = ScanCntBits'(cmp_idx_ff) < CoolEnd;
   assign in_slot  = ScanCntBits'(cmp_idx_ff) < SlotEnd;
   assign cmp_last = cmp_vld_ff && (cmp_idx_ff == ScanLast);

   // An entry never written since reset or a clear reads as empty with expiry zero
   assign eff_key = cool_vld_ff[cidx] ? cool_rdata[CoolWidth-1:ClockBits] : '0;
   assign eff_exp = cool_vld_ff[cidx] ? cool_rdata[ClockBits-1:0] : '0;

   assign cool_key_hit = (eff_key == key_ff);
   assign slot_key_hit = (slot_rkey == key_ff);

   // Shared less-than: cooling test (now < expiry) or victim choice
   // (expiry < earliest so far)
   assign lt_a = (state_ff == S_ARM) ? eff_exp : now_ff;
   assign lt_b = (state_ff == S_ARM) ? earliest_ff : eff_exp;
   assign lt   = lt_a < lt_b;

   // Saturating expiry for a new cooldown
   assign expiry_sum = {1'b0, now_ff} + (ClockBits + 1)'(ticks_ff);
   assign expiry     = expiry_sum[ClockBits] ? '1 : expiry_sum[ClockBits-1:0];

   always_comb begin
      state_in       = state_ff;
      action_in      = action_ff;
      key_in         = key_ff;
      slot_in        = slot_ff;
      backoff_in     = backoff_ff;
      scan_cnt_in    = scan_cnt_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      cool_seen_in   = cool_seen_ff;
      cooling_in     = cooling_ff;
      inflight_in    = inflight_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      pick_vld_in    = pick_vld_ff;
      pick_idx_in    = pick_idx_ff;
      earliest_in    = earliest_ff;
      res_status_in  = res_status_ff;
      res_slot_in    = res_slot_ff;
      slot_active_in = slot_active_ff;
      cool_vld_in    = cool_vld_ff;
      total_in       = total_ff;
      now_in         = now_ff;
      limit_in       = limit_ff;
      ticks_in       = ticks_ff;
      enabled_in     = enabled_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_count_in   = rsp_count_ff;
      slot_we        = 1'b0;
      slot_waddr     = free_idx_ff;
      cool_we        = 1'b0;
      cool_waddr     = pick_idx_ff;

      // The user must make configuration writes only while idle; the block does not enforce it
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_LIMIT:  limit_in   = csr_wr_data[LimitBits-1:0];
            CSR_TICKS:  ticks_in   = csr_wr_data[TicksBits-1:0];
            CSR_ENABLE: enabled_in = csr_wr_data[0];
            default: ;
         endcase
      end

      // Advance the walk: one read issued per cycle until every entry is out
      if (state_ff == S_SCAN || state_ff == S_ARM) begin
         if (scan_cnt_ff < ScanEnd) begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            cmp_vld_in  = 1'b1;
            cmp_idx_in  = scan_cnt_ff[ScanIdxBits-1:0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               action_in     = action_type'(req_action);
               key_in        = KeyBits'(req_item_key);
               slot_in       = req_slot_index;
               backoff_in    = req_backoff;
               scan_cnt_in   = '0;
               cool_seen_in  = 1'b0;
               cooling_in    = 1'b0;
               inflight_in   = 1'b0;
               free_found_in = 1'b0;
               pick_vld_in   = 1'b0;
               res_status_in = ST_DONE;
               res_slot_in   = '0;
               case (action_type'(req_action))
                  ACT_CLAIM:   state_in = S_SCAN;
                  ACT_RELEASE: state_in = S_REL_READ;
                  ACT_CLEAR: begin
                     cool_vld_in = '0;
                     state_in    = S_RESP;
                  end
                  ACT_TICK: begin
                     if (now_ff != '1) begin
                        now_in = now_ff + 1'b1;
                     end
                     state_in = S_RESP;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end

         S_SCAN: begin
            if (cmp_vld_ff) begin
               // Only the lowest cooldown entry holding the key counts
               if (in_cool && !cool_seen_ff && cool_key_hit) begin
                  cool_seen_in = 1'b1;
                  cooling_in   = lt;
               end
               if (in_slot) begin
                  if (slot_active_ff[sidx] && slot_key_hit) begin
                     inflight_in = 1'b1;
                  end
                  if (!slot_active_ff[sidx] && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = sidx;
                  end
               end
            end
            if (cmp_last) begin
               state_in = S_RESP;
               if (cooling_in) begin
                  res_status_in = ST_COOLING;
               end else if (!enabled_ff || (9'(total_ff) >= 9'(limit_ff))) begin
                  res_status_in = ST_CAPACITY;
               end else if (inflight_in) begin
                  res_status_in = ST_INFLIGHT;
               end else if (!free_found_in) begin
                  res_status_in = ST_CAPACITY;
               end else begin
                  res_status_in               = ST_GRANTED;
                  res_slot_in                 = free_idx_in;
                  slot_we                     = 1'b1;
                  slot_waddr                  = free_idx_in;
                  slot_active_in[free_idx_in] = 1'b1;
                  total_in                    = total_ff + 1'b1;
               end
            end
         end

         S_REL_READ: begin
            state_in = S_REL_CHECK;
         end

         S_REL_CHECK: begin
            if ((9'(slot_ff) < 9'(SlotCount)) && slot_active_ff[rel_idx] && slot_key_hit) begin
               slot_active_in[rel_idx] = 1'b0;
               if (total_ff != '0) begin
                  total_in = total_ff - 1'b1;
               end
            end
            if (backoff_ff) begin
               scan_cnt_in = '0;
               state_in    = S_ARM;
            end else begin
               state_in = S_RESP;
            end
         end

         S_ARM: begin
            if (cmp_vld_ff) begin
               if (in_cool && cool_key_hit) begin
                  // Entry already holding the key: take it and stop
                  cool_we           = 1'b1;
                  cool_waddr        = cidx;
                  cool_vld_in[cidx] = 1'b1;
                  state_in          = S_RESP;
               end else begin
                  if (in_cool && (!pick_vld_ff || (eff_key == '0) || lt)) begin
                     pick_vld_in = 1'b1;
                     pick_idx_in = cidx;
                     earliest_in = eff_exp;
                  end
                  if (cmp_last) begin
                     cool_we                  = 1'b1;
                     cool_waddr               = pick_idx_in;
                     cool_vld_in[pick_idx_in] = 1'b1;
                     state_in                 = S_RESP;
                  end
               end
            end
         end

         S_RESP: begin
            // Hold the result until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = SlotPortBits'(res_slot_ff);
               rsp_count_in  = CountPortBits'(total_ff);
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      key_ff        <= key_in;
      slot_ff       <= slot_in;
      backoff_ff    <= backoff_in;
      cmp_idx_ff    <= cmp_idx_in;
      cool_seen_ff  <= cool_seen_in;
      cooling_ff    <= cooling_in;
      inflight_ff   <= inflight_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      pick_vld_ff   <= pick_vld_in;
      pick_idx_ff   <= pick_idx_in;
      earliest_ff   <= earliest_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         scan_cnt_ff    <= '0;
         cmp_vld_ff     <= 1'b0;
         slot_active_ff <= '0;
         cool_vld_ff    <= '0;
         total_ff       <= '0;
         now_ff         <= '0;
         limit_ff       <= LimitReset;
         ticks_ff       <= TicksReset;
         enabled_ff     <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         scan_cnt_ff    <= scan_cnt_in;
         cmp_vld_ff     <= cmp_vld_in;
         slot_active_ff <= slot_active_in;
         cool_vld_ff    <= cool_vld_in;
         total_ff       <= total_in;
         now_ff         <= now_in;
         limit_ff       <= limit_in;
         ticks_ff       <= ticks_in;
         enabled_ff     <= enabled_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_slot_ff;
   assign rsp_active_count = rsp_count_ff;

endmodule

FILE: hw/rtl/wsa_checker.sv
// Port-level checks on the worker slot allocator, bound to its top level.
// Depends on wsa_pkg.
module wsa_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [wsa_pkg::ActionBits-1:0]    req_action,
   input logic [wsa_pkg::ItemKeyBits-1:0]   req_item_key,
   input logic [wsa_pkg::SlotPortBits-1:0]  req_slot_index,
   input logic                              req_backoff,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [wsa_pkg::StatusBits-1:0]    rsp_status,
   input logic [wsa_pkg::SlotPortBits-1:0]  rsp_granted_slot,
   input logic [wsa_pkg::CountPortBits-1:0] rsp_active_count,
   input logic                              csr_wr_en,
   input logic [wsa_pkg::CsrIndexBits-1:0]  csr_index,
   input logic [wsa_pkg::CsrDataBits-1:0]   csr_wr_data
);
   import wsa_pkg::*;

   // A stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_granted_slot) && $stable(rsp_active_count))
      else $error("response changed while stalled");

   // Only a grant carries a slot number
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_GRANTED) |-> rsp_granted_slot == '0)
      else $error("slot reported without a grant");

   // A grant leaves at least one slot active
   a_grant_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_GRANTED) |-> rsp_active_count != '0)
      else $error("grant with no active slot");

   // The count never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_active_count <= CountPortBits'(SlotCount))
      else $error("active count beyond slot table");

   // Ready drops after each accepted request transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

endmodule

bind worker_slot_allocator_with_cooldown_top wsa_checker u_wsa_checker (.*);

FILE: sim/tb_worker_slot_allocator_with_cooldown_top.sv
// Self-checking testbench for the worker slot allocator with cooldown.
// Depends on wsa_pkg and the RTL of worker_slot_allocator_with_cooldown_top;
// it keeps its own model of the slot and cooldown tables.
module tb_worker_slot_allocator_with_cooldown_top;
   import wsa_pkg::*;

   localparam int QuietLimit    = 4000;  // cycles with no transaction on either side
   localparam int DrainCycles   = 80;
   localparam int PressureHold  = 400;   // long receiver hold-off

   typedef struct packed {
      action_type                act;
      logic [ItemKeyBits-1:0]    key;
      logic [SlotPortBits-1:0]   slot;
      logic                      backoff;
   } alloc_request_type;

   typedef struct packed {
      status_type                st;
      logic [SlotPortBits-1:0]   slot;
      logic [CountPortBits-1:0]  count;
   } alloc_reply_type;

   // DUT connections; every input starts at a known value
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [ActionBits-1:0]     req_action = ACT_TICK;
   logic [ItemKeyBits-1:0]    req_item_key = '0;
   logic [SlotPortBits-1:0]   req_slot_index = '0;
   logic                      req_backoff = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [StatusBits-1:0]     rsp_status;
   logic [SlotPortBits-1:0]   rsp_granted_slot;
   logic [CountPortBits-1:0]  rsp_active_count;
   logic                      csr_wr_en = 1'b0;
   logic [CsrIndexBits-1:0]   csr_index = CSR_LIMIT;
   logic [CsrDataBits-1:0]    csr_wr_data = '0;

   worker_slot_allocator_with_cooldown_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_item_key     (req_item_key),
      .req_slot_index   (req_slot_index),
      .req_backoff      (req_backoff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_active_count (rsp_active_count),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   always #4 clock = ~clock;

   // Shadow of the allocator: slot table, cooldown table, tick clock and registers
   logic                      slot_busy   [SlotCount];
   logic [KeyBits-1:0]        slot_owner  [SlotCount];
   logic [CountPortBits-1:0]  busy_total;
   logic [KeyBits-1:0]        cool_owner  [CoolEntries];
   logic [ClockBits-1:0]      cool_expiry [CoolEntries];
   logic [ClockBits-1:0]      tick_now;
   logic [LimitBits-1:0]      slot_limit  = LimitReset;
   logic [TicksBits-1:0]      cool_span   = TicksReset;
   logic                      claims_on   = 1'b1;

   alloc_request_type request_backlog[$];   // items waiting for the driver
   alloc_reply_type   replies_due[$];       // predicted replies, oldest first
   alloc_request_type on_wire;

   int queued_total   = 0;
   int accepted_total = 0;
   int replies_seen   = 0;
   int bad_count      = 0;
   int quiet_cycles   = 0;

   // Stimulus shaping, set per phase by the sequence below
   int req_gap_odds = 4;     // 0: no random sender gaps
   int rsp_gap_odds = 4;     // 0: no random receiver stalls
   int claim_pct    = 45;
   int release_pct  = 30;
   logic [KeyBits-1:0] key_pool[$];

   function automatic void wipe_cooldowns();
      for (int i = 0; i < CoolEntries; i++) begin
         cool_owner[i]  = '0;
         cool_expiry[i] = '0;
      end
   endfunction

   // Work out the reply to one accepted request and advance the shadow state.
   function automatic alloc_reply_type allocate_and_reply(alloc_request_type rq);
      alloc_reply_type  r;
      logic             cooling;
      logic             seen;
      logic             dup;
      int               free_at;
      int               pick;
      logic [ClockBits-1:0] earliest;
      logic [ClockBits:0]   expiry_sum;
      r.st    = ST_DONE;
      r.slot  = '0;
      cooling = 1'b0;
      seen    = 1'b0;
      dup     = 1'b0;
      free_at = -1;
      pick    = -1;
      earliest = '0;
      case (rq.act)
         ACT_CLAIM: begin
            // only the lowest cooldown entry holding the key decides
            for (int i = 0; i < CoolEntries; i++) begin
               if (!seen && cool_owner[i] == rq.key) begin
                  seen    = 1'b1;
                  cooling = cool_expiry[i] > tick_now;
               end
            end
            if (cooling) begin
               r.st = ST_COOLING;
            end else if (!claims_on || busy_total >= slot_limit) begin
               r.st = ST_CAPACITY;
            end else begin
               for (int i = 0; i < SlotCount; i++) begin
                  if (slot_busy[i] && slot_owner[i] == rq.key) dup = 1'b1;
                  if (!slot_busy[i] && free_at < 0) free_at = i;
               end
               if (dup) begin
                  r.st = ST_INFLIGHT;
               end else if (free_at < 0) begin
                  r.st = ST_CAPACITY;
               end else begin
                  slot_busy[free_at]  = 1'b1;
                  slot_owner[free_at] = rq.key;
                  busy_total          = busy_total + 1'b1;
                  r.st   = ST_GRANTED;
                  r.slot = SlotPortBits'(free_at);
               end
            end
         end
         ACT_RELEASE: begin
            if (int'(rq.slot) < SlotCount && slot_busy[rq.slot]
                && slot_owner[rq.slot] == rq.key) begin
               slot_busy[rq.slot]  = 1'b0;
               slot_owner[rq.slot] = '0;
               if (busy_total != 0) busy_total = busy_total - 1'b1;
            end
            if (rq.backoff) begin
               // own entry first, else the last empty one, else the earliest expiry
               seen = 1'b0;
               for (int i = 0; i < CoolEntries; i++) begin
                  if (!seen) begin
                     if (cool_owner[i] == rq.key) begin
                        pick = i;
                        seen = 1'b1;
                     end else if (pick < 0 || cool_owner[i] == '0
                                  || cool_expiry[i] < earliest) begin
                        pick     = i;
                        earliest = cool_expiry[i];
                     end
                  end
               end
               expiry_sum = {1'b0, tick_now} + (ClockBits+1)'(cool_span);
               cool_owner[pick]  = rq.key;
               cool_expiry[pick] = expiry_sum[ClockBits] ? '1 : expiry_sum[ClockBits-1:0];
            end
         end
         ACT_CLEAR: wipe_cooldowns();
         default: begin
            if (tick_now != '1) tick_now = tick_now + 1'b1;
         end
      endcase
      r.count = busy_total;
      return r;
   endfunction

   function automatic logic [KeyBits-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85 && key_pool.size() != 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (roll < 95) return $urandom();
      return ($urandom_range(0, 1) != 0) ? '1 : '0;
   endfunction

   // Mostly claims and well-formed releases over a small key pool; the rest is noise.
   function automatic alloc_request_type make_request();
      alloc_request_type rq;
      int roll;
      int held[$];
      rq.key     = pick_key();
      rq.slot    = SlotPortBits'($urandom_range(0, SlotCount - 1));
      rq.backoff = 1'($urandom_range(0, 1));
      roll       = $urandom_range(0, 99);
      if (roll < claim_pct) begin
         rq.act = ACT_CLAIM;
      end else if (roll < claim_pct + release_pct) begin
         rq.act = ACT_RELEASE;
         if ($urandom_range(0, 9) < 8) begin
            for (int i = 0; i < SlotCount; i++) if (slot_busy[i]) held.push_back(i);
            if (held.size() != 0) begin
               rq.slot = SlotPortBits'(held[$urandom_range(0, held.size() - 1)]);
               rq.key  = slot_owner[rq.slot];
            end
         end
      end else if (roll < 97) begin
         rq.act = ACT_TICK;
      end else begin
         rq.act = ACT_CLEAR;
      end
      return rq;
   endfunction

   task automatic flag_mismatch(string what, longint got, longint want);
      bad_count++;
      $display("mismatch in %s at reply %0d: got %0d, want %0d",
               what, replies_seen, got, want);
   endtask

   // Sender: drain the backlog, one transaction at a time, with random gaps.
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            replies_due.push_back(allocate_and_reply(on_wire));
            accepted_total++;
         end
         // hold the payload until accepted; otherwise the channel is free
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_gap_odds != 0 && $urandom_range(0, req_gap_odds) == 0) begin
               gap_left = $urandom_range(0, 10);
               req_valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               on_wire = request_backlog.pop_front();
               req_valid      <= 1'b1;
               req_action     <= on_wire.act;
               req_item_key   <= on_wire.key;
               req_slot_index <= on_wire.slot;
               req_backoff    <= on_wire.backoff;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each reply against the oldest prediction, stall at random,
   // and twice hold off long enough for the block to back up into its input.
   int hold_left = 0;
   int pressure_marks[2] = '{150, 1200};
   int pressure_idx = 0;
   alloc_reply_type due;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            replies_seen++;
            if (replies_due.size() == 0) begin
               flag_mismatch("unexpected reply, status", rsp_status, -1);
            end else begin
               due = replies_due.pop_front();
               if (rsp_status != due.st)
                  flag_mismatch("status", rsp_status, due.st);
               if (rsp_granted_slot != due.slot)
                  flag_mismatch("granted_slot", rsp_granted_slot, due.slot);
               if (rsp_active_count != due.count)
                  flag_mismatch("active_count", rsp_active_count, due.count);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (pressure_idx < 2 && replies_seen >= pressure_marks[pressure_idx]) begin
            pressure_idx++;
            hold_left = PressureHold - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_gap_odds != 0 && $urandom_range(0, rsp_gap_odds) == 0) begin
            hold_left = $urandom_range(0, 10);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_request(action_type act, logic [KeyBits-1:0] key,
                                int slot, logic backoff);
      alloc_request_type rq;
      rq.act     = act;
      rq.key     = key;
      rq.slot    = SlotPortBits'(slot);
      rq.backoff = backoff;
      request_backlog.push_back(rq);
      queued_total++;
   endtask

   // Wait until every queued transaction is accepted and answered.
   task automatic drain_block();
      do @(negedge clock);
      while (accepted_total != queued_total || replies_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_csr(csr_index_type idx, logic [CsrDataBits-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         CSR_LIMIT: slot_limit = value[LimitBits-1:0];
         CSR_TICKS: cool_span  = value[TicksBits-1:0];
         default:   claims_on  = value[0];
      endcase
   endtask

   task automatic run_phase(int count, int pool_size, int claims, int releases,
                            int req_odds, int rsp_odds);
      key_pool.delete();
      for (int i = 0; i < pool_size; i++) key_pool.push_back($urandom());
      claim_pct    = claims;
      release_pct  = releases;
      req_gap_odds = req_odds;
      rsp_gap_odds = rsp_odds;
      for (int n = 0; n < count; n++) begin
         // keep the backlog short so releases see a fresh slot table
         while (request_backlog.size() >= 2) @(negedge clock);
         request_backlog.push_back(make_request());
         queued_total++;
      end
   endtask

   initial begin
      for (int i = 0; i < SlotCount; i++) begin
         slot_busy[i]  = 1'b0;
         slot_owner[i] = '0;
      end
      wipe_cooldowns();
      busy_total = '0;
      tick_now   = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed opening at reset settings: limit 8, cooldown 30, enabled.
      queue_request(ACT_CLAIM,   32'h0000_0000, 0,  1'b0);  // key zero is an ordinary key
      queue_request(ACT_CLAIM,   32'hFFFF_FFFF, 0,  1'b1);
      queue_request(ACT_CLAIM,   32'hFFFF_FFFF, 63, 1'b0);  // already in flight
      queue_request(ACT_RELEASE, 32'h0000_0005, 63, 1'b1);  // idle slot: frees nothing, still arms
      queue_request(ACT_CLAIM,   32'h0000_0005, 0,  1'b0);  // cooling
      queue_request(ACT_TICK,    32'h0000_0000, 0,  1'b0);
      queue_request(ACT_CLEAR,   32'h0000_0000, 0,  1'b0);
      queue_request(ACT_CLAIM,   32'h0000_0005, 0,  1'b0);  // granted once cleared
      queue_request(ACT_RELEASE, 32'hFFFF_FFFF, 2,  1'b0);  // slot holds another key
      queue_request(ACT_RELEASE, 32'h0000_0000, 0,  1'b1);  // arms a cooldown for key zero
      queue_request(ACT_CLAIM,   32'h0000_0000, 0,  1'b0);
      queue_request(ACT_RELEASE, 32'hFFFF_FFFF, 1,  1'b1);
      queue_request(ACT_CLAIM,   32'hFFFF_FFFF, 0,  1'b0);
      // fill up to the limit and one past it
      for (int k = 1; k <= 8; k++) queue_request(ACT_CLAIM, 32'hA5A5_0000 + k, 0, 1'b0);
      queue_request(ACT_RELEASE, 32'hA5A5_0001, 0,  1'b0);
      queue_request(ACT_CLAIM,   32'h5A5A_FFFE, 0,  1'b0);
      queue_request(ACT_TICK,    32'hDEAD_BEEF, 42, 1'b1);  // unused fields ignored
      queue_request(ACT_CLEAR,   32'h1234_5678, 21, 1'b1);
      drain_block();

      run_phase(350, 14, 45, 30, 4, 4);

      // Wide limit, one-tick cooldown: fill most slots, see cooldowns lapse.
      drain_block();
      write_csr(CSR_LIMIT, 16'd64);
      write_csr(CSR_TICKS, 16'd1);
      run_phase(300, 80, 55, 15, 3, 5);

      // Single slot, longest cooldown.
      drain_block();
      write_csr(CSR_LIMIT, 16'd1);
      write_csr(CSR_TICKS, 16'hFFFF);
      run_phase(200, 6, 45, 30, 0, 3);

      // Disabled: every claim not cooling reports capacity.
      drain_block();
      write_csr(CSR_ENABLE, 16'd0);
      run_phase(200, 6, 50, 30, 5, 2);

      // Limit zero and a zero-length cooldown.
      drain_block();
      write_csr(CSR_ENABLE, 16'd1);
      write_csr(CSR_LIMIT, 16'd0);
      write_csr(CSR_TICKS, 16'd0);
      run_phase(150, 8, 45, 30, 4, 4);

      // Limit above the slot count (upper bits dropped): run out of free slots.
      drain_block();
      write_csr(CSR_LIMIT, 16'hFFFF);
      write_csr(CSR_TICKS, 16'd5);
      run_phase(400, 90, 60, 12, 4, 6);

      // Closing stretch at full rate on both sides.
      drain_block();
      write_csr(CSR_LIMIT, 16'd5);
      write_csr(CSR_TICKS, 16'd12);
      run_phase(300, 10, 45, 30, 0, 0);

      drain_block();
      repeat (DrainCycles) @(posedge clock);
      if (bad_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
